// File: rtl/core/dns_pkg.sv
// Shared types and constants for the decimal to scientific notation block.
`timescale 1ns / 1ps

package dns_pkg;

  localparam int DIGIT_W     = 4;
  localparam int EXP_OUT_W   = 9;
  localparam int SIG_W       = 5;
  localparam int SIG_RESET   = 3;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  typedef enum logic [1:0] {
    PH_LEAD      = 2'd0,
    PH_INT       = 2'd1,
    PH_FRAC_ZERO = 2'd2,
    PH_FRAC_SIG  = 2'd3
  } phase_t;

  // Per-number values that hold for every digit of the run.
  typedef struct packed {
    logic signed [EXP_OUT_W-1:0] exponent;
    logic                        is_zero;
  } num_meta_t;

endpackage

// File: rtl/core/dns_front.sv
// Front end: per-character scan, digit capture and exponent tracking.
`timescale 1ns / 1ps

module dns_front #(
  parameter int MAX_SIG_DIGITS = 16,
  parameter int EXP_LIMIT      = 255,
  parameter int CNT_W          = 5,
  parameter int KIDX_W         = 4,
  parameter int REC_W          = 84
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [dns_pkg::DIGIT_W-1:0] in_digit,
  input  logic                        in_is_point,
  input  logic                        in_end_of_number,
  input  logic                        q_full,
  input  logic [dns_pkg::SIG_W-1:0]   sig_digits,
  output logic                        in_stall,
  output logic                        push,
  output logic [REC_W-1:0]            push_data
);

  localparam int EXP_W = $clog2(EXP_LIMIT + 1) + 1;
  localparam logic signed [EXP_W-1:0] EXP_MAX = EXP_W'(EXP_LIMIT);
  localparam logic signed [EXP_W-1:0] EXP_MIN = -EXP_MAX;

  dns_pkg::phase_t            phase_r, phase_nxt;
  logic signed [EXP_W-1:0]    exp_r, exp_nxt;
  logic [CNT_W-1:0]           kept_r, kept_nxt;
  logic                       int_nz_r, int_nz_nxt;
  logic [dns_pkg::DIGIT_W-1:0] digits_r [MAX_SIG_DIGITS];

  logic                        accept;
  logic [dns_pkg::DIGIT_W-1:0] d;
  logic                        keep, exp_up, exp_dn, room;
  logic [MAX_SIG_DIGITS*dns_pkg::DIGIT_W-1:0] digits_flat;
  logic [CNT_W-1:0]            num_n, rec_kept;
  dns_pkg::num_meta_t          meta;
  logic signed [EXP_W-1:0]     exp_sc;
  logic                        zero;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign d        = (in_digit > dns_pkg::DIGIT_MAX) ? dns_pkg::DIGIT_MAX : in_digit;
  assign room     = 32'(kept_r) < 32'(MAX_SIG_DIGITS);

  always_comb begin
    phase_nxt  = phase_r;
    int_nz_nxt = int_nz_r;
    keep       = 1'b0;
    exp_up     = 1'b0;
    exp_dn     = 1'b0;
    if (in_is_point) begin
      if (phase_r == dns_pkg::PH_LEAD) phase_nxt = dns_pkg::PH_FRAC_ZERO;
      else if (phase_r == dns_pkg::PH_INT) phase_nxt = dns_pkg::PH_FRAC_SIG;
    end else begin
      case (phase_r)
        dns_pkg::PH_LEAD: begin
          if (d != '0) begin
            keep       = 1'b1;
            exp_up     = 1'b1;
            int_nz_nxt = 1'b1;
            phase_nxt  = dns_pkg::PH_INT;
          end
        end
        dns_pkg::PH_INT: begin
          keep   = 1'b1;
          exp_up = 1'b1;
        end
        dns_pkg::PH_FRAC_ZERO: begin
          if (d == '0) begin
            exp_dn = 1'b1;
          end else begin
            keep      = 1'b1;
            phase_nxt = dns_pkg::PH_FRAC_SIG;
          end
        end
        default: keep = 1'b1;
      endcase
    end

    exp_sc = exp_r;
    if (exp_up && exp_r != EXP_MAX) exp_sc = exp_r + EXP_W'(1);
    if (exp_dn && exp_r != EXP_MIN) exp_sc = exp_r - EXP_W'(1);
    kept_nxt = (keep && room) ? kept_r + CNT_W'(1) : kept_r;
    exp_nxt  = exp_sc;
  end

  // Digit capture this cycle is merged in so the record is complete on the end item.
  always_comb begin
    for (int i = 0; i < MAX_SIG_DIGITS; i++) begin
      if (keep && room && kept_r[KIDX_W-1:0] == KIDX_W'(i))
        digits_flat[i*dns_pkg::DIGIT_W +: dns_pkg::DIGIT_W] = d;
      else
        digits_flat[i*dns_pkg::DIGIT_W +: dns_pkg::DIGIT_W] = digits_r[i];
    end
  end

  always_comb begin
    if (sig_digits == '0)
      num_n = CNT_W'(1);
    else if (32'(sig_digits) > 32'(MAX_SIG_DIGITS))
      num_n = CNT_W'(MAX_SIG_DIGITS);
    else
      num_n = CNT_W'(sig_digits);
    zero          = (phase_nxt == dns_pkg::PH_LEAD) || (phase_nxt == dns_pkg::PH_FRAC_ZERO);
    meta.is_zero  = zero;
    meta.exponent = zero ? '0 : dns_pkg::EXP_OUT_W'(exp_nxt);
    rec_kept      = zero ? '0 : kept_nxt;
  end

  assign push      = accept && in_end_of_number;
  assign push_data = {meta, num_n, rec_kept, digits_flat};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= dns_pkg::PH_LEAD;
      exp_r    <= '0;
      kept_r   <= '0;
      int_nz_r <= 1'b0;
    end else if (accept) begin
      if (in_end_of_number) begin
        phase_r  <= dns_pkg::PH_LEAD;
        exp_r    <= '0;
        kept_r   <= '0;
        int_nz_r <= 1'b0;
      end else begin
        phase_r  <= phase_nxt;
        exp_r    <= exp_nxt;
        kept_r   <= kept_nxt;
        int_nz_r <= int_nz_nxt;
      end
    end
  end

  // Store is not cleared: entries at or above the kept count are masked downstream.
  always_ff @(posedge clk) begin
    if (accept && keep && room && !in_end_of_number)
      digits_r[kept_r[KIDX_W-1:0]] <= d;
  end

endmodule

// File: rtl/core/dns_queue.sv
// Two-entry record queue between front and back ends.
`timescale 1ns / 1ps

module dns_queue #(
  parameter int REC_W = 84
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [REC_W-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output logic [REC_W-1:0] head
);

  logic [REC_W-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
    else $error("pop from empty queue");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
      (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

// File: rtl/core/dns_back.sv
// Back end: plays out one digit per transaction from the head record.
`timescale 1ns / 1ps

module dns_back #(
  parameter int MAX_SIG_DIGITS = 16,
  parameter int CNT_W          = 5,
  parameter int KIDX_W         = 4,
  parameter int REC_W          = 84
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  input  logic [REC_W-1:0]                     head,
  input  logic                                 out_stall,
  output logic                                 pop,
  output logic                                 out_valid,
  output logic [dns_pkg::DIGIT_W-1:0]          out_digit,
  output logic signed [dns_pkg::EXP_OUT_W-1:0] out_exponent,
  output logic                                 out_is_zero,
  output logic                                 out_last
);

  localparam int DIG_BITS = MAX_SIG_DIGITS * dns_pkg::DIGIT_W;

  logic [CNT_W-1:0]    k_r, k_nxt;
  logic [DIG_BITS-1:0] digits;
  logic [CNT_W-1:0]    kept, num_n;
  dns_pkg::num_meta_t  meta;
  logic                take;

  assign {meta, num_n, kept, digits} = head;

  assign out_valid    = !q_empty;
  assign out_exponent = meta.exponent;
  assign out_is_zero  = meta.is_zero;
  assign out_last     = (k_r + CNT_W'(1)) == num_n;
  assign out_digit    = (k_r < kept) ?
                        digits[k_r[KIDX_W-1:0]*dns_pkg::DIGIT_W +: dns_pkg::DIGIT_W] : '0;

  assign take = out_valid && !out_stall;
  assign pop  = take && out_last;

  always_comb begin
    k_nxt = k_r;
    if (take) k_nxt = out_last ? '0 : k_r + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) k_r <= '0;
    else        k_r <= k_nxt;
  end

endmodule

// File: rtl/core/decimal_to_normalized_sci_top.sv
// Top level: decimal character stream to normalized scientific notation.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    in_digit, in_is_point, in_end_of_number
//   out      output     out_valid/out_stall  out_digit, out_exponent, out_is_zero, out_last
//   cfg      input      cfg_we               cfg_data (sig_digits)
//
// One character is scanned per cycle unless stalled. Each number yields sig_digits
// output transactions, clamped to 1..MAX_SIG_DIGITS, one per cycle from the back end
// unless stalled. A two-entry record queue separates the scan from playout; the input
// stalls only while both entries are held. Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps

module decimal_to_normalized_sci_top #(
  parameter int MAX_SIG_DIGITS = 16,
  parameter int EXP_LIMIT      = 255
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [dns_pkg::DIGIT_W-1:0]          in_digit,
  input  logic                                 in_is_point,
  input  logic                                 in_end_of_number,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [dns_pkg::DIGIT_W-1:0]          out_digit,
  output logic signed [dns_pkg::EXP_OUT_W-1:0] out_exponent,
  output logic                                 out_is_zero,
  output logic                                 out_last,
  input  logic                                 cfg_we,
  input  logic [dns_pkg::SIG_W-1:0]            cfg_data
);

  localparam int CNT_W  = $clog2(MAX_SIG_DIGITS + 1);
  localparam int KIDX_W = (MAX_SIG_DIGITS > 1) ? $clog2(MAX_SIG_DIGITS) : 1;
  localparam int REC_W  = MAX_SIG_DIGITS * dns_pkg::DIGIT_W + 2 * CNT_W
                          + $bits(dns_pkg::num_meta_t);

  logic [dns_pkg::SIG_W-1:0] sig_digits_r;
  logic                      q_full, q_empty, push, pop;
  logic [REC_W-1:0]          push_data, head;

  always_ff @(posedge clk) begin
    if (!rst_n)      sig_digits_r <= dns_pkg::SIG_W'(dns_pkg::SIG_RESET);
    else if (cfg_we) sig_digits_r <= cfg_data;
  end

  dns_front #(
    .MAX_SIG_DIGITS(MAX_SIG_DIGITS),
    .EXP_LIMIT     (EXP_LIMIT),
    .CNT_W         (CNT_W),
    .KIDX_W        (KIDX_W),
    .REC_W         (REC_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_digit        (in_digit),
    .in_is_point     (in_is_point),
    .in_end_of_number(in_end_of_number),
    .q_full          (q_full),
    .sig_digits      (sig_digits_r),
    .in_stall        (in_stall),
    .push            (push),
    .push_data       (push_data)
  );

  dns_queue #(
    .REC_W(REC_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  dns_back #(
    .MAX_SIG_DIGITS(MAX_SIG_DIGITS),
    .CNT_W         (CNT_W),
    .KIDX_W        (KIDX_W),
    .REC_W         (REC_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .head        (head),
    .out_stall   (out_stall),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_digit   (out_digit),
    .out_exponent(out_exponent),
    .out_is_zero (out_is_zero),
    .out_last    (out_last)
  );

endmodule
